@@ rtl/rtoi_pkg.sv @@
// ----------------------------------------------------------------------------
// rtoi_pkg
// Shared types and constants of the recording time-to-offset index.
// ----------------------------------------------------------------------------
`default_nettype none

package rtoi_pkg;

  localparam int TIME_W  = 40;
  localparam int SIZE_W  = 48;
  localparam int QT_W    = 56;
  localparam int ALIGN_W = 12;
  localparam int FRAC_BITS = 16;
  localparam int SEG_AW  = 8;
  localparam int CNT_W   = SEG_AW + 1;
  localparam int MAX_SEGMENTS = 1 << SEG_AW;

  // multiplier / divider operand widths
  localparam int MA_W = SIZE_W + 1;
  localparam int MB_W = QT_W;
  localparam int MP_W = MA_W + MB_W;
  localparam int DD_W = QT_W;

  localparam logic [ALIGN_W-1:0] ALIGN_RESET = ALIGN_W'(188);

  localparam logic [2:0] ST_APPENDED = 3'd0;
  localparam logic [2:0] ST_NEW_SEG  = 3'd1;
  localparam logic [2:0] ST_DROP_OLD = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_QUERY    = 3'd4;

  typedef struct packed {
    logic              multi;
    logic [SIZE_W-1:0] last_size;
    logic [TIME_W-1:0] last_time;
    logic [SIZE_W-1:0] first_size;
    logic [TIME_W-1:0] first_time;
  } seg_t;

endpackage

`default_nettype wire

@@ rtl/rtoi_seg_ram.sv @@
// ----------------------------------------------------------------------------
// rtoi_seg_ram
// Segment table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rtoi_seg_ram
  import rtoi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [SEG_AW-1:0] waddr,
  input  wire seg_t              wdata,
  input  wire logic [SEG_AW-1:0] raddr,
  output seg_t                   rdata
);

  seg_t mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/rtoi_mul.sv @@
// ----------------------------------------------------------------------------
// rtoi_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rtoi_mul
  import rtoi_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [MA_W-1:0] a,
  input  wire logic [MB_W-1:0] b,
  output logic                 done,
  output logic [MP_W-1:0]      prod
);

  localparam int CW = $clog2(MB_W + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [MA_W:0] sum;

  assign sum = {1'b0, prod[MP_W-1:MB_W]} + (prod[0] ? {1'b0, a} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MB_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= {{MA_W{1'b0}}, b};
    end else if (busy) begin
      prod <= {sum, prod[MB_W-1:1]};
    end
  end

endmodule

`default_nettype wire

@@ rtl/rtoi_div.sv @@
// ----------------------------------------------------------------------------
// rtoi_div
// Restoring divider, one quotient bit per cycle, with remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rtoi_div
  import rtoi_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [MP_W-1:0] num,
  input  wire logic [DD_W-1:0] den,
  output logic                 done,
  output logic [MP_W-1:0]      quo,
  output logic [DD_W-1:0]      rem
);

  localparam int CW = $clog2(MP_W + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [DD_W-1:0] d;
  logic [DD_W:0]   r2;
  logic            ge;

  assign r2 = {rem, quo[MP_W-1]};
  assign ge = r2 >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MP_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      quo <= {quo[MP_W-2:0], ge};
      rem <= ge ? DD_W'(r2 - {1'b0, d}) : r2[DD_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/recording_time_to_offset_index.sv @@
// ----------------------------------------------------------------------------
// recording_time_to_offset_index
// Segment index of a growing recording; maps wall time to byte offset.
// ----------------------------------------------------------------------------
// One word is worked on at a time. An append that runs the split test uses
// two passes of the shift-add multiplier. A query scans the segment table one
// entry a cycle through the memory read port, then uses one multiply and two
// divisions (interpolation, then packet alignment); an empty table or a
// single-sample tail segment skips the multiply and the interpolation.
`default_nettype none

module recording_time_to_offset_index
  import rtoi_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [11:0]  cfg_wdata,   // packet_align
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [143:0] s_tdata,     // sample_time, sample_size, query_time
  input  wire logic         s_tuser,     // opcode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata,     // byte_position, timeline_valid,
                                         // timeline_start, timeline_duration
  output logic [2:0]        m_tuser      // status
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ACHK    = 4'd1;
  localparam logic [3:0] S_AM1     = 4'd2;
  localparam logic [3:0] S_AM1W    = 4'd3;
  localparam logic [3:0] S_AM2     = 4'd4;
  localparam logic [3:0] S_AM2W    = 4'd5;
  localparam logic [3:0] S_AUPD    = 4'd6;
  localparam logic [3:0] S_QSCAN   = 4'd7;
  localparam logic [3:0] S_QMUL    = 4'd8;
  localparam logic [3:0] S_QMULW   = 4'd9;
  localparam logic [3:0] S_QDIV    = 4'd10;
  localparam logic [3:0] S_QDIVW   = 4'd11;
  localparam logic [3:0] S_QALN    = 4'd12;
  localparam logic [3:0] S_QALNW   = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0] state;
  logic [ALIGN_W-1:0] packet_align;

  logic              op;
  logic [TIME_W-1:0] t_in;
  logic [SIZE_W-1:0] s_in;
  logic [QT_W-1:0]   tq;

  seg_t              tail;
  logic [CNT_W-1:0]  count;
  logic [TIME_W-1:0] start_time;
  logic [2:0]        status;
  logic              split;

  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [DD_W-1:0] den;
  logic [SIZE_W-1:0] base;
  logic            down;
  logic [SIZE_W-1:0] pos;
  logic [MP_W-1:0] p1;

  logic [CNT_W-1:0] scan_idx;
  logic             rd_vld;

  // ram
  logic              ram_we;
  logic [SEG_AW-1:0] ram_waddr;
  seg_t              ram_wdata;
  seg_t              rdata;

  rtoi_seg_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx[SEG_AW-1:0]),
    .rdata (rdata)
  );

  // arithmetic units
  logic            mul_start, mul_done;
  logic [MP_W-1:0] mul_p;
  logic            div_start, div_done;
  logic [MP_W-1:0] div_num, div_q;
  logic [DD_W-1:0] div_den, div_r;

  assign mul_start = (state == S_AM1) || (state == S_AM2) || (state == S_QMUL);
  assign div_start = (state == S_QDIV) || (state == S_QALN);

  rtoi_mul u_mul (
    .clk (clk), .rst (rst), .start (mul_start),
    .a (mul_a), .b (mul_b), .done (mul_done), .prod (mul_p)
  );

  logic [ALIGN_W-1:0] align_eff;
  assign align_eff = (packet_align == '0) ? ALIGN_W'(1) : packet_align;
  assign div_num = (state == S_QALN) ? MP_W'(pos) : mul_p;
  assign div_den = (state == S_QALN) ? DD_W'(align_eff) : den;

  rtoi_div u_div (
    .clk (clk), .rst (rst), .start (div_start),
    .num (div_num), .den (div_den), .done (div_done), .quo (div_q), .rem (div_r)
  );

  // append arithmetic
  logic [SIZE_W-1:0] dv, aa;
  logic [TIME_W-1:0] tt, dt;
  assign dv = s_in - tail.last_size;
  assign aa = tail.last_size - tail.first_size;
  assign tt = tail.last_time - tail.first_time;
  assign dt = t_in - tail.last_time;

  seg_t new_seg, ext_seg;
  always_comb begin
    new_seg = '{multi: 1'b0, last_size: s_in, last_time: t_in,
                first_size: s_in, first_time: t_in};
    ext_seg = tail;
    ext_seg.last_time = t_in;
    ext_seg.last_size = s_in;
    ext_seg.multi     = 1'b1;
  end

  // query arithmetic
  logic [QT_W-1:0] r_t0f, r_t1f, t_t0f, t_t1f;
  logic [SIZE_W-1:0] r_bytes;
  logic            match;
  assign r_t0f = {rdata.first_time, FRAC_BITS'(0)};
  assign r_t1f = {rdata.last_time, FRAC_BITS'(0)};
  assign t_t0f = {tail.first_time, FRAC_BITS'(0)};
  assign t_t1f = {tail.last_time, FRAC_BITS'(0)};
  assign r_bytes = rdata.last_size - rdata.first_size;
  assign match = rd_vld && rdata.multi && (tq <= r_t1f);

  logic          qbig;
  logic [SIZE_W:0] up_sum, dn_q;
  assign qbig   = |div_q[MP_W-1:SIZE_W];
  assign up_sum = {1'b0, base} + {1'b0, div_q[SIZE_W-1:0]};
  assign dn_q   = {1'b0, div_q[SIZE_W-1:0]} + {{SIZE_W{1'b0}}, (div_r != '0)};

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_align <= ALIGN_RESET;
    end else if (cfg_we) begin
      packet_align <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      start_time <= '0;
      m_tvalid   <= 1'b0;
      rd_vld     <= 1'b0;
      ram_we     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op       <= s_tuser;
            t_in     <= s_tdata[39:0];
            s_in     <= s_tdata[87:40];
            tq       <= s_tdata[143:88];
            scan_idx <= '0;
            rd_vld   <= 1'b0;
            pos      <= '0;
            state    <= s_tuser ? S_QSCAN : S_ACHK;
          end
        end
        S_ACHK: begin
          if (count == '0) begin
            tail       <= new_seg;
            ram_we     <= 1'b1;
            ram_waddr  <= '0;
            ram_wdata  <= new_seg;
            count      <= CNT_W'(1);
            start_time <= t_in;
            status     <= ST_NEW_SEG;
            state      <= S_DONE;
          end else if (t_in <= tail.last_time) begin
            status <= ST_DROP_OLD;
            state  <= S_DONE;
          end else if (tail.multi && (aa != '0)) begin
            mul_a <= {dv, 1'b0};
            mul_b <= MB_W'(tt);
            state <= S_AM1;
          end else begin
            split <= 1'b0;
            state <= S_AUPD;
          end
        end
        S_AM1: state <= S_AM1W;
        S_AM1W: begin
          if (mul_done) begin
            p1    <= mul_p;
            mul_a <= MA_W'(tt) + MA_W'(aa);
            mul_b <= MB_W'(dt);
            state <= S_AM2;
          end
        end
        S_AM2: state <= S_AM2W;
        S_AM2W: begin
          if (mul_done) begin
            split <= p1 < mul_p;
            state <= S_AUPD;
          end
        end
        S_AUPD: begin
          if (split) begin
            if (count[CNT_W-1]) begin
              status <= ST_FULL;
            end else begin
              tail      <= new_seg;
              ram_we    <= 1'b1;
              ram_waddr <= count[SEG_AW-1:0];
              ram_wdata <= new_seg;
              count     <= count + 1'b1;
              status    <= ST_NEW_SEG;
            end
          end else begin
            tail      <= ext_seg;
            ram_we    <= 1'b1;
            ram_waddr <= SEG_AW'(count - 1'b1);
            ram_wdata <= ext_seg;
            status    <= ST_APPENDED;
          end
          state <= S_DONE;
        end
        S_QSCAN: begin
          status <= ST_QUERY;
          if (match) begin
            rd_vld <= 1'b0;
            mul_a  <= {1'b0, r_bytes};
            mul_b  <= (tq > r_t0f) ? tq - r_t0f : '0;
            den    <= r_t1f - r_t0f;
            base   <= rdata.first_size;
            down   <= 1'b0;
            state  <= S_QMUL;
          end else if (scan_idx < count) begin
            scan_idx <= scan_idx + 1'b1;
            rd_vld   <= 1'b1;
          end else if (rd_vld) begin
            rd_vld <= 1'b0;
          end else if (count == '0) begin
            pos   <= '0;
            state <= S_QALN;
          end else if (!tail.multi) begin
            pos   <= tail.last_size;
            state <= S_QALN;
          end else begin
            mul_a <= {1'b0, aa};
            mul_b <= (tq >= t_t1f) ? tq - t_t1f : t_t1f - tq;
            down  <= tq < t_t1f;
            den   <= t_t1f - t_t0f;
            base  <= tail.last_size;
            state <= S_QMUL;
          end
        end
        S_QMUL: state <= S_QMULW;
        S_QMULW: begin
          if (mul_done) begin
            state <= S_QDIV;
          end
        end
        S_QDIV: state <= S_QDIVW;
        S_QDIVW: begin
          if (div_done) begin
            if (down) begin
              pos <= (qbig || (dn_q >= {1'b0, base})) ? '0 : SIZE_W'({1'b0, base} - dn_q);
            end else begin
              pos <= (qbig || up_sum[SIZE_W]) ? '1 : up_sum[SIZE_W-1:0];
            end
            state <= S_QALN;
          end
        end
        S_QALN: state <= S_QALNW;
        S_QALNW: begin
          if (div_done) begin
            pos   <= pos - div_r[SIZE_W-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          ram_we <= 1'b0;
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status;
            m_tdata  <= {7'd0,
                         (count != '0) ? tail.last_time - start_time : TIME_W'(0),
                         (count != '0) ? start_time : TIME_W'(0),
                         (count != '0),
                         op ? pos : SIZE_W'(0)};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
